// ===== design/segment_point_hit_test_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment point hit test unit
// ----------------------------------------------------------------------------
`ifndef SEGMENT_POINT_HIT_TEST_UNIT_MACROS_SVH
`define SEGMENT_POINT_HIT_TEST_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define SPH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sphit_pkg.sv =====
// ----------------------------------------------------------------------------
// sphit_pkg
// Shared types and constants of the segment point hit test unit.
// ----------------------------------------------------------------------------
`default_nettype none
package sphit_pkg;
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int QUO_W     = 40;
	localparam int QH_W      = 18;
	localparam int REG_W     = 31;

	localparam logic [REG_W-1:0] HIT_RADIUS_RST = REG_W'(64'd1 << (FRAC_BITS - 1));
	localparam logic [REG_W-1:0] MIN_STEP_RST   = REG_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

	localparam logic [2:0] ADDR_HIT_RADIUS = 3'd0;
	localparam logic [2:0] ADDR_MIN_STEP   = 3'd4;

	typedef enum logic [2:0] {
		VERD_HIT,
		VERD_OWNER,
		VERD_NOT_OPP,
		VERD_SHORT,
		VERD_OUTSIDE,
		VERD_OFF_PATH
	} verdict_t;

	typedef struct packed {
		logic     early;
		verdict_t code;
		logic     neg;
		logic     outside;
	} pre_t;
endpackage
`default_nettype wire

// ===== design/sphit_front.sv =====
// ----------------------------------------------------------------------------
// sphit_front
// Differences, products, sums and early checks over four pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none
module sphit_front import sphit_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       in_beat,
	input  wire logic signed [COORD_W-1:0]  start_x,
	input  wire logic signed [COORD_W-1:0]  start_y,
	input  wire logic signed [COORD_W-1:0]  start_z,
	input  wire logic signed [COORD_W-1:0]  end_x,
	input  wire logic signed [COORD_W-1:0]  end_y,
	input  wire logic signed [COORD_W-1:0]  end_z,
	input  wire logic signed [COORD_W-1:0]  point_x,
	input  wire logic signed [COORD_W-1:0]  point_y,
	input  wire logic signed [COORD_W-1:0]  point_z,
	input  wire logic                       target_is_owner,
	input  wire logic [1:0]                 target_kind,
	input  wire logic                       shooter_is_player,
	input  wire logic [REG_W-1:0]           min_step,
	output logic                            valid_s4,
	output logic [SUM_W-1:0]                l2_s4,
	output logic [SUM_W-1:0]                mag_s4,
	output logic [SUM_W-1:0]                tt_s4,
	output pre_t                            pre_s4
);
	logic signed [COORD_W-1:0] s_c [3];
	logic signed [COORD_W-1:0] e_c [3];
	logic signed [COORD_W-1:0] p_c [3];
	logic                      opp;

	logic                      valid_s1, valid_s2, valid_s3;
	logic signed [DIFF_W-1:0]  d_s1 [3];
	logic signed [DIFF_W-1:0]  t_s1 [3];
	pre_t                      pre_s1, pre_s2, pre_s3;
	logic signed [PROD_W-1:0]  dd_s2 [3];
	logic signed [PROD_W-1:0]  tt_s2 [3];
	logic signed [PROD_W-1:0]  td_s2 [3];
	logic [2*REG_W-1:0]        msl2_s2, msl2_s3;
	logic signed [SUM_W-1:0]   l2_s3, tt_s3, dot_s3;

	assign s_c = '{start_x, start_y, start_z};
	assign e_c = '{end_x, end_y, end_z};
	assign p_c = '{point_x, point_y, point_z};
	assign opp = shooter_is_player ? target_kind[0] : target_kind[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_beat;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DIFF_W'(e_c[i]) - DIFF_W'(s_c[i]);
				t_s1[i]  <= DIFF_W'(p_c[i]) - DIFF_W'(s_c[i]);
				dd_s2[i] <= d_s1[i] * d_s1[i];
				tt_s2[i] <= t_s1[i] * t_s1[i];
				td_s2[i] <= t_s1[i] * d_s1[i];
			end
			pre_s1.early   <= target_is_owner || !opp;
			pre_s1.code    <= target_is_owner ? VERD_OWNER : VERD_NOT_OPP;
			pre_s1.neg     <= 1'b0;
			pre_s1.outside <= 1'b0;
			pre_s2         <= pre_s1;
			msl2_s2        <= (2*REG_W)'(min_step) * (2*REG_W)'(min_step);
			l2_s3  <= SUM_W'(dd_s2[0]) + SUM_W'(dd_s2[1]) + SUM_W'(dd_s2[2]);
			tt_s3  <= SUM_W'(tt_s2[0]) + SUM_W'(tt_s2[1]) + SUM_W'(tt_s2[2]);
			dot_s3 <= SUM_W'(td_s2[0]) + SUM_W'(td_s2[1]) + SUM_W'(td_s2[2]);
			msl2_s3 <= msl2_s2;
			pre_s3  <= pre_s2;
			l2_s4  <= l2_s3;
			tt_s4  <= tt_s3;
			mag_s4 <= dot_s3[SUM_W-1] ? SUM_W'(-dot_s3) : dot_s3;
			pre_s4.early   <= pre_s3.early || (SUM_W'(msl2_s3) > l2_s3);
			pre_s4.code    <= pre_s3.early ? pre_s3.code : VERD_SHORT;
			pre_s4.neg     <= dot_s3[SUM_W-1];
			pre_s4.outside <= dot_s3[SUM_W-1] || (dot_s3 > l2_s3);
		end
	end
endmodule
`default_nettype wire

// ===== design/sphit_isqrt.sv =====
// ----------------------------------------------------------------------------
// sphit_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module sphit_isqrt import sphit_pkg::*; #(
	parameter int N   = ROOT_W,
	parameter int SBW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_v,
	input  wire logic [2*N-1:0]   x,
	input  wire logic [SBW-1:0]   sb_in,
	output logic                  out_v,
	output logic [N-1:0]          root,
	output logic [SBW-1:0]        sb_out
);
	logic             v_a    [N];
	logic [2*N-1:0]   x_a    [N];
	logic [N+1:0]     rem_a  [N];
	logic [N-1:0]     root_a [N];
	logic [SBW-1:0]   sb_a   [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic           pv;
		logic [2*N-1:0] px;
		logic [N+1:0]   prem;
		logic [N-1:0]   proot;
		logic [SBW-1:0] psb;
		logic [N+3:0]   rem_sh, trial, diff;
		logic           ge;

		if (i == 0) begin : g_first
			assign pv    = in_v;
			assign px    = x;
			assign prem  = '0;
			assign proot = '0;
			assign psb   = sb_in;
		end else begin : g_next
			assign pv    = v_a[i-1];
			assign px    = x_a[i-1];
			assign prem  = rem_a[i-1];
			assign proot = root_a[i-1];
			assign psb   = sb_a[i-1];
		end

		assign rem_sh = {prem, px[2*N-1:2*N-2]};
		assign trial  = {2'b00, proot, 2'b01};
		assign ge     = rem_sh >= trial;
		assign diff   = rem_sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_a[i] <= 1'b0;
			end else if (adv) begin
				v_a[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_a[i]    <= px << 2;
				rem_a[i]  <= ge ? diff[N+1:0] : rem_sh[N+1:0];
				root_a[i] <= {proot[N-2:0], ge};
				sb_a[i]   <= psb;
			end
		end
	end

	assign out_v  = v_a[N-1];
	assign root   = root_a[N-1];
	assign sb_out = sb_a[N-1];
endmodule
`default_nettype wire

// ===== design/sphit_div.sv =====
// ----------------------------------------------------------------------------
// sphit_div
// Pipelined restoring divider, one quotient bit per stage, capped quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module sphit_div import sphit_pkg::*; #(
	parameter int NW  = SUM_W,
	parameter int DW  = ROOT_W,
	parameter int QW  = QUO_W,
	parameter int SBW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_v,
	input  wire logic [NW-1:0]    num,
	input  wire logic [DW-1:0]    den,
	input  wire logic [SBW-1:0]   sb_in,
	output logic                  out_v,
	output logic [QW-1:0]         quo,
	output logic [SBW-1:0]        sb_out
);
	logic             v0_q, ovf0_q, zero0_q;
	logic [DW-1:0]    rem0_q, den0_q;
	logic [QW-1:0]    nl0_q;
	logic [SBW-1:0]   sb0_q;

	logic             v_a    [QW];
	logic             ovf_a  [QW];
	logic             zero_a [QW];
	logic [DW-1:0]    rem_a  [QW];
	logic [DW-1:0]    den_a  [QW];
	logic [QW-1:0]    nl_a   [QW];
	logic [QW-1:0]    q_a    [QW];
	logic [SBW-1:0]   sb_a   [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
		end else if (adv) begin
			v0_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero0_q <= den == '0;
			ovf0_q  <= (DW+QW)'(num) >= {den, {QW{1'b0}}};
			rem0_q  <= DW'(num[NW-1:QW]);
			nl0_q   <= num[QW-1:0];
			den0_q  <= den;
			sb0_q   <= sb_in;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic           pv, povf, pzero;
		logic [DW-1:0]  prem, pden;
		logic [QW-1:0]  pnl, pq;
		logic [SBW-1:0] psb;
		logic [DW:0]    rem_sh, diff;
		logic           ge;

		if (i == 0) begin : g_first
			assign pv    = v0_q;
			assign povf  = ovf0_q;
			assign pzero = zero0_q;
			assign prem  = rem0_q;
			assign pden  = den0_q;
			assign pnl   = nl0_q;
			assign pq    = '0;
			assign psb   = sb0_q;
		end else begin : g_next
			assign pv    = v_a[i-1];
			assign povf  = ovf_a[i-1];
			assign pzero = zero_a[i-1];
			assign prem  = rem_a[i-1];
			assign pden  = den_a[i-1];
			assign pnl   = nl_a[i-1];
			assign pq    = q_a[i-1];
			assign psb   = sb_a[i-1];
		end

		assign rem_sh = {prem, pnl[QW-1]};
		assign ge     = rem_sh >= {1'b0, pden};
		assign diff   = rem_sh - {1'b0, pden};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_a[i] <= 1'b0;
			end else if (adv) begin
				v_a[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ovf_a[i]  <= povf;
				zero_a[i] <= pzero;
				rem_a[i]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
				den_a[i]  <= pden;
				nl_a[i]   <= pnl << 1;
				q_a[i]    <= {pq[QW-2:0], ge};
				sb_a[i]   <= psb;
			end
		end
	end

	assign out_v  = v_a[QW-1];
	assign quo    = zero_a[QW-1] ? '0 : (ovf_a[QW-1] ? '1 : q_a[QW-1]);
	assign sb_out = sb_a[QW-1];
endmodule
`default_nettype wire

// ===== design/sphit_tail.sv =====
// ----------------------------------------------------------------------------
// sphit_tail
// Along distance, quotient square and leftover squared distance, two stages.
// ----------------------------------------------------------------------------
`default_nettype none
module sphit_tail import sphit_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_v,
	input  wire logic [QUO_W-1:0]    quo,
	input  wire logic [SUM_W-1:0]    tt,
	input  wire pre_t                pre,
	output logic                     valid_s2,
	output logic [SUM_W-1:0]         rem_s2,
	output logic [COORD_W-1:0]       along_s2,
	output pre_t                     pre_s2
);
	localparam logic [QUO_W-1:0] POS_MAX = QUO_W'(32'h7FFF_FFFF);
	localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'(32'h8000_0000);

	logic                      valid_s1;
	logic [2*QH_W-1:0]         phh_s1, phl_s1, pll_s1;
	logic [SUM_W-1:0]          tt_s1;
	logic [COORD_W-1:0]        along_s1;
	pre_t                      pre_s1;
	logic [COORD_W-1:0]        along_c;
	logic [2*SUM_W-1:0]        q2_c;

	always_comb begin
		if (pre.early) begin
			along_c = '0;
		end else if (pre.neg) begin
			along_c = (quo > NEG_MAX) ? NEG_MAX[COORD_W-1:0] : COORD_W'(-quo);
		end else begin
			along_c = (quo > POS_MAX) ? POS_MAX[COORD_W-1:0] : quo[COORD_W-1:0];
		end
	end

	assign q2_c = ((2*SUM_W)'(phh_s1) << (2*QH_W)) + ((2*SUM_W)'(phl_s1) << (QH_W + 1))
		+ (2*SUM_W)'(pll_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_v;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phh_s1   <= quo[2*QH_W-1:QH_W] * quo[2*QH_W-1:QH_W];
			phl_s1   <= quo[2*QH_W-1:QH_W] * quo[QH_W-1:0];
			pll_s1   <= quo[QH_W-1:0] * quo[QH_W-1:0];
			tt_s1    <= tt;
			along_s1 <= along_c;
			pre_s1   <= pre;
			rem_s2   <= (q2_c <= (2*SUM_W)'(tt_s1)) ? SUM_W'((2*SUM_W)'(tt_s1) - q2_c) : '0;
			along_s2 <= along_s1;
			pre_s2   <= pre_s1;
		end
	end
endmodule
`default_nettype wire

// ===== design/segment_point_hit_test_unit.sv =====
// ----------------------------------------------------------------------------
// segment_point_hit_test_unit
// Point versus projectile step segment hit test, fully pipelined.
// ----------------------------------------------------------------------------
// One segment/target pair enters per clock unless stalled; it passes four
// stages of differences, products and sums, 34 stages of step length square
// root (one root bit each), 41 stages of division of the dot product by
// that length (one quotient bit each but the first), two stages of quotient
// squaring, 34 stages of path distance square root and one output register.
// While the output beat is stalled the whole pipeline holds and in_stall is
// high. Registers: hit_radius at byte 0, min_step_length at byte 4.
`default_nettype none
module segment_point_hit_test_unit import sphit_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [COORD_W-1:0] start_x,
	input  wire logic signed [COORD_W-1:0] start_y,
	input  wire logic signed [COORD_W-1:0] start_z,
	input  wire logic signed [COORD_W-1:0] end_x,
	input  wire logic signed [COORD_W-1:0] end_y,
	input  wire logic signed [COORD_W-1:0] end_z,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic signed [COORD_W-1:0] point_z,
	input  wire logic                      target_is_owner,
	input  wire logic [1:0]                target_kind,
	input  wire logic                      shooter_is_player,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           hit,
	output logic [2:0]                     verdict,
	output logic signed [COORD_W-1:0]      along_distance,
	output logic [REG_W-1:0]               path_distance
);
	localparam int SB1_W = 2 * SUM_W + $bits(pre_t);
	localparam int SB2_W = SUM_W + $bits(pre_t);
	localparam int SB3_W = COORD_W + $bits(pre_t);

	logic [REG_W-1:0]   hit_radius_q, min_step_q;
	logic               adv;
	logic               fr_v;
	logic [SUM_W-1:0]   fr_l2, fr_mag, fr_tt;
	pre_t               fr_pre;
	logic               sq1_v;
	logic [ROOT_W-1:0]  sq1_len;
	logic [SB1_W-1:0]   sq1_sb;
	logic [SUM_W-1:0]   sq1_mag, sq1_tt;
	pre_t               sq1_pre;
	logic               dv_v;
	logic [QUO_W-1:0]   dv_q;
	logic [SB2_W-1:0]   dv_sb;
	logic [SUM_W-1:0]   dv_tt;
	pre_t               dv_pre;
	logic               tl_v;
	logic [SUM_W-1:0]   tl_rem;
	logic [COORD_W-1:0] tl_along;
	pre_t               tl_pre;
	logic               sq2_v;
	logic [ROOT_W-1:0]  sq2_root;
	logic [SB3_W-1:0]   sq2_sb;
	logic [COORD_W-1:0] sq2_along;
	pre_t               sq2_pre;
	logic [REG_W-1:0]   path_c;
	verdict_t           verd_c;
	logic               out_valid_q;
	verdict_t           verdict_q;
	logic [COORD_W-1:0] along_q;
	logic [REG_W-1:0]   path_q;

	assign pready = 1'b1;
	assign prdata = {1'b0, (paddr == ADDR_MIN_STEP) ? min_step_q : hit_radius_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_radius_q <= HIT_RADIUS_RST;
			min_step_q   <= MIN_STEP_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_HIT_RADIUS) begin
				hit_radius_q <= pwdata[REG_W-1:0];
			end
			if (paddr == ADDR_MIN_STEP) begin
				min_step_q <= pwdata[REG_W-1:0];
			end
		end
	end

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	sphit_front u_front (
		.clk, .arst_n, .adv,
		.in_beat (in_valid),
		.start_x, .start_y, .start_z, .end_x, .end_y, .end_z,
		.point_x, .point_y, .point_z,
		.target_is_owner, .target_kind, .shooter_is_player,
		.min_step (min_step_q),
		.valid_s4 (fr_v),
		.l2_s4    (fr_l2),
		.mag_s4   (fr_mag),
		.tt_s4    (fr_tt),
		.pre_s4   (fr_pre)
	);

	sphit_isqrt #(.N(ROOT_W), .SBW(SB1_W)) u_len_sqrt (
		.clk, .arst_n, .adv,
		.in_v   (fr_v),
		.x      (fr_l2),
		.sb_in  ({fr_mag, fr_tt, fr_pre}),
		.out_v  (sq1_v),
		.root   (sq1_len),
		.sb_out (sq1_sb)
	);
	assign {sq1_mag, sq1_tt, sq1_pre} = sq1_sb;

	sphit_div #(.NW(SUM_W), .DW(ROOT_W), .QW(QUO_W), .SBW(SB2_W)) u_div (
		.clk, .arst_n, .adv,
		.in_v   (sq1_v),
		.num    (sq1_mag),
		.den    (sq1_len),
		.sb_in  ({sq1_tt, sq1_pre}),
		.out_v  (dv_v),
		.quo    (dv_q),
		.sb_out (dv_sb)
	);
	assign {dv_tt, dv_pre} = dv_sb;

	sphit_tail u_tail (
		.clk, .arst_n, .adv,
		.in_v     (dv_v),
		.quo      (dv_q),
		.tt       (dv_tt),
		.pre      (dv_pre),
		.valid_s2 (tl_v),
		.rem_s2   (tl_rem),
		.along_s2 (tl_along),
		.pre_s2   (tl_pre)
	);

	sphit_isqrt #(.N(ROOT_W), .SBW(SB3_W)) u_path_sqrt (
		.clk, .arst_n, .adv,
		.in_v   (tl_v),
		.x      (tl_rem),
		.sb_in  ({tl_along, tl_pre}),
		.out_v  (sq2_v),
		.root   (sq2_root),
		.sb_out (sq2_sb)
	);
	assign {sq2_along, sq2_pre} = sq2_sb;

	always_comb begin
		path_c = (sq2_root > ROOT_W'({REG_W{1'b1}})) ? '1 : sq2_root[REG_W-1:0];
		if (sq2_pre.early) begin
			verd_c = sq2_pre.code;
			path_c = '0;
		end else if (sq2_pre.outside) begin
			verd_c = VERD_OUTSIDE;
			path_c = '0;
		end else begin
			verd_c = (path_c <= hit_radius_q) ? VERD_HIT : VERD_OFF_PATH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sq2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			verdict_q <= verd_c;
			along_q   <= sq2_along;
			path_q    <= path_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = verdict_q == VERD_HIT;
	assign verdict        = verdict_q;
	assign along_distance = along_q;
	assign path_distance  = path_q;
endmodule
`default_nettype wire

// ===== design/sphit_checker.sv =====
// ----------------------------------------------------------------------------
// sphit_checker
// Port-level checks of the hit test unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "segment_point_hit_test_unit_macros.svh"
module sphit_checker import sphit_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic                 hit,
	input wire logic [2:0]           verdict,
	input wire logic [COORD_W-1:0]   along_distance,
	input wire logic [REG_W-1:0]     path_distance
);
	`SPH_ASSERT_IMP(a_hit_code, out_valid, hit == (verdict == VERD_HIT), "hit flag disagrees with verdict")
	`SPH_ASSERT_IMP(a_early_zero, out_valid && (verdict == VERD_OWNER || verdict == VERD_NOT_OPP || verdict == VERD_SHORT), along_distance == '0 && path_distance == '0, "early reject carries distances")
	`SPH_ASSERT_IMP(a_outside_path, out_valid && verdict == VERD_OUTSIDE, path_distance == '0, "outside segment carries path distance")
	`SPH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(verdict) && $stable(along_distance), "stalled output beat changed")
endmodule

bind segment_point_hit_test_unit sphit_checker u_sphit_checker (.*);
`default_nettype wire

// ===== dv/segment_point_hit_test_unit_tb.sv =====
// ----------------------------------------------------------------------------
// segment_point_hit_test_unit_tb
// Drives step segment and target beats through the hit test pipeline and
// compares every result beat with an in-bench exact integer predictor, over
// directed corner cases, random near-path targets and several register
// settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module segment_point_hit_test_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sphit_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 150;

	typedef struct {
		logic signed [31:0] sx, sy, sz, ex, ey, ez, px, py, pz;
		logic               owner;
		logic [1:0]         kind;
		logic               shooter_player;
	} step_beat_t;

	typedef struct {
		logic               hit;
		verdict_t           code;
		logic signed [31:0] along;
		logic [REG_W-1:0]   path;
	} verdict_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic target_is_owner = 1'b0;
	logic [1:0] target_kind = '0;
	logic shooter_is_player = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [2:0] verdict;
	logic signed [31:0] along_distance;
	logic [REG_W-1:0] path_distance;

	logic [REG_W-1:0] radius_reg = HIT_RADIUS_RST;
	logic [REG_W-1:0] min_step_reg = MIN_STEP_RST;
	verdict_beat_t awaited_verdicts[$];
	int send_gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int beats_sent = 0;
	int verdict_seen[6];

	always #5 clk = ~clk;

	segment_point_hit_test_unit uut (.*);

	function automatic logic [63:0] floor_sqrt(logic [127:0] x);
		logic [63:0] r, c;
		r = '0;
		for (int b = 36; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= x) r = c;
		end
		return r;
	endfunction

	function automatic verdict_beat_t judge_step(step_beat_t s);
		logic signed [127:0] st[3], d[3], t[3];
		logic signed [127:0] l2, tt, dot;
		logic [127:0] m, q, q2, rem, len, path;
		logic neg;
		verdict_beat_t r;
		st[0] = s.sx; st[1] = s.sy; st[2] = s.sz;
		d[0] = s.ex; d[1] = s.ey; d[2] = s.ez;
		t[0] = s.px; t[1] = s.py; t[2] = s.pz;
		l2 = 0; tt = 0; dot = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = d[i] - st[i];
			t[i] = t[i] - st[i];
			l2 = l2 + d[i] * d[i];
			tt = tt + t[i] * t[i];
			dot = dot + t[i] * d[i];
		end
		neg = dot < 0;
		r.along = '0;
		r.path = '0;
		if (s.owner) begin
			r.code = VERD_OWNER;
		end else if (!(s.shooter_player ? s.kind[0] : s.kind[1])) begin
			r.code = VERD_NOT_OPP;
		end else if ({97'd0, min_step_reg} * {97'd0, min_step_reg} > $unsigned(l2)) begin
			r.code = VERD_SHORT;
		end else begin
			len = floor_sqrt($unsigned(l2));
			m = neg ? $unsigned(-dot) : $unsigned(dot);
			q = '0;
			if (len != 0) q = m / len;
			if (q > 128'hFF_FFFF_FFFF) q = 128'hFF_FFFF_FFFF;
			if (neg) r.along = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
			else r.along = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
			if (neg || dot > l2) begin
				r.code = VERD_OUTSIDE;
			end else begin
				q2 = q * q;
				rem = (q2 <= $unsigned(tt)) ? $unsigned(tt) - q2 : '0;
				path = floor_sqrt(rem);
				if (path > 128'h7FFF_FFFF) path = 128'h7FFF_FFFF;
				r.path = path[REG_W-1:0];
				r.code = (path <= radius_reg) ? VERD_HIT : VERD_OFF_PATH;
			end
		end
		r.hit = r.code == VERD_HIT;
		return r;
	endfunction

	task automatic apb_write(logic [2:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_HIT_RADIUS) radius_reg = value[REG_W-1:0];
		else if (addr == ADDR_MIN_STEP) min_step_reg = value[REG_W-1:0];
	endtask

	task automatic wait_drained();
		while (awaited_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic set_registers(logic [31:0] radius, logic [31:0] min_step);
		wait_drained();
		apb_write(ADDR_HIT_RADIUS, radius);
		apb_write(ADDR_MIN_STEP, min_step);
	endtask

	task automatic send_step(step_beat_t s);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= s.sx; start_y <= s.sy; start_z <= s.sz;
		end_x <= s.ex; end_y <= s.ey; end_z <= s.ez;
		point_x <= s.px; point_y <= s.py; point_z <= s.pz;
		target_is_owner <= s.owner;
		target_kind <= s.kind;
		shooter_is_player <= s.shooter_player;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		awaited_verdicts = {awaited_verdicts, judge_step(s)};
		beats_sent++;
	endtask

	task automatic idle_sender();
		in_valid <= 1'b0;
	endtask

	function automatic step_beat_t mk_step(int sx, int sy, int sz, int ex, int ey, int ez,
			int px, int py, int pz);
		step_beat_t s;
		s.sx = sx; s.sy = sy; s.sz = sz;
		s.ex = ex; s.ey = ey; s.ez = ez;
		s.px = px; s.py = py; s.pz = pz;
		s.owner = 1'b0;
		s.kind = 2'b01;
		s.shooter_player = 1'b1;
		return s;
	endfunction

	function automatic step_beat_t random_step();
		step_beat_t s;
		int k;
		if ($urandom_range(99) < 20) begin
			s.sx = $urandom; s.sy = $urandom; s.sz = $urandom;
			s.ex = $urandom; s.ey = $urandom; s.ez = $urandom;
			s.px = $urandom; s.py = $urandom; s.pz = $urandom;
			s.owner = 1'($urandom);
			s.kind = 2'($urandom);
			s.shooter_player = 1'($urandom);
			return s;
		end
		s.sx = $urandom; s.sy = $urandom; s.sz = $urandom;
		if ($urandom_range(9) == 0) begin
			s.ex = s.sx + $signed($urandom_range(0, 128)) - 64;
			s.ey = s.sy + $signed($urandom_range(0, 128)) - 64;
			s.ez = s.sz;
		end else begin
			s.ex = s.sx + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
			s.ey = s.sy + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
			s.ez = s.sz + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
		end
		k = $urandom_range(0, 20) - 2;
		s.px = s.sx + ((s.ex - s.sx) / 16) * k + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
		s.py = s.sy + ((s.ey - s.sy) / 16) * k + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
		s.pz = s.sz + ((s.ez - s.sz) / 16) * k + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
		s.owner = ($urandom_range(99) < 5);
		s.shooter_player = 1'($urandom);
		s.kind = s.shooter_player ? 2'b01 : 2'b10;
		if ($urandom_range(99) < 20) s.kind = 2'($urandom);
		return s;
	endfunction

	task automatic test_directed();
		step_beat_t s;
		s = mk_step(0, 0, 0, 10 << 16, 0, 0, 5 << 16, 1 << 14, 0);
		send_step(s);
		s.px = 5 << 16; s.py = 2 << 16;
		send_step(s);
		s.owner = 1'b1;
		send_step(s);
		s.owner = 1'b0; s.kind = 2'b10;
		send_step(s);
		s.shooter_player = 1'b0;
		send_step(s);
		s.kind = 2'b00;
		send_step(s);
		s.kind = 2'b11; s.shooter_player = 1'b1;
		send_step(s);
		s = mk_step(0, 0, 0, 10, 0, 0, 5, 0, 0);
		send_step(s);
		s = mk_step(0, 0, 0, 10 << 16, 0, 0, -(1 << 16), 0, 0);
		send_step(s);
		s.px = 11 << 16;
		send_step(s);
		s.px = 0;
		send_step(s);
		s.px = 10 << 16;
		send_step(s);
		s = mk_step(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_step(s);
		s.px = 32'sh8000_0000;
		send_step(s);
		s = mk_step(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF, 0);
		send_step(s);
		s = mk_step(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_step(s);
		idle_sender();
		set_registers(32'h0, 32'h0);
		s = mk_step(7, 7, 7, 7, 7, 7, 7 + (3 << 16), 7, 7);
		send_step(s);
		s.px = 7;
		send_step(s);
		s = mk_step(0, 0, 0, 1, 0, 0, 1, 0, 0);
		send_step(s);
		idle_sender();
		set_registers(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		s = mk_step(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
		send_step(s);
		s = mk_step(0, 0, 0, 10 << 16, 0, 0, 5 << 16, 1 << 20, 0);
		send_step(s);
		idle_sender();
	endtask

	task automatic test_random(int count, int gap_pct, int stall_percent, bit pause_mid);
		send_gap_pct = gap_pct;
		stall_pct = stall_percent;
		for (int i = 0; i < count; i++) begin
			send_step(random_step());
			if (pause_mid && i == count / 2) begin
				idle_sender();
				wait_drained();
			end
		end
		idle_sender();
	endtask

	always @(posedge clk) begin
		out_stall <= arst_n && stall_pct != 0 && $urandom_range(99) < stall_pct;
	end

	always @(posedge clk) begin
		verdict_beat_t e;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, awaited_verdicts.size());
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
			end else begin
				e = awaited_verdicts.pop_front();
				verdict_seen[e.code]++;
				if (hit !== e.hit || verdict !== e.code || along_distance !== e.along
						|| path_distance !== e.path) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at %0t: exp hit %0b verdict %0d along %0d ",
							"path %0d, got hit %0b verdict %0d along %0d path %0d"},
							$realtime, e.hit, e.code, e.along, e.path,
							hit, verdict, along_distance, path_distance);
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_registers(HIT_RADIUS_RST, MIN_STEP_RST);
		test_random(230, 0, 0, 1'b0);
		set_registers(32'd1 << 16, 32'd1 << 10);
		test_random(230, 81, 0, 1'b1);
		set_registers($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 16));
		test_random(230, 0, 81, 1'b0);
		set_registers(32'h7FFF_FFFF, 32'd0);
		test_random(230, 20, 20, 1'b0);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display({"%0d beats sent: %0d hit, %0d owner, %0d not opponent, %0d short, ",
			"%0d outside, %0d off path"},
			beats_sent, verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
			verdict_seen[4], verdict_seen[5]);
		$display("reset values plus six register settings, four idle phases, mismatches: %0d",
			mismatches);
		if (mismatches == 0 && awaited_verdicts.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
